// File: hdl/crng_pkg.sv
// Package for the combined LCG generator with shuffle table: constants, types, helpers.
`timescale 1ns / 1ps

package crng_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int WARMUP_STEPS  = 8;
    localparam int SEED_STEPS    = WARMUP_STEPS + TABLE_ENTRIES;
    localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
    localparam int Q_W           = SLOT_W + 1;
    localparam int STEP_W        = $clog2(SEED_STEPS);

    localparam logic [30:0] MOD_A     = 31'd2147483563;
    localparam logic [30:0] MOD_B     = 31'd2147483399;
    localparam logic [15:0] MUL_A     = 16'd40014;
    localparam logic [15:0] MUL_B     = 16'd40692;
    // 2^31 mod MOD_A and 2^31 mod MOD_B
    localparam logic [7:0]  FOLD_A    = 8'd85;
    localparam logic [7:0]  FOLD_B    = 8'd249;
    localparam logic [30:0] WRAP_ADD  = 31'd2147483562;
    localparam logic [30:0] OUT_LIMIT = 31'd2147483305;
    localparam logic [30:0] SECOND_INIT = 31'd123456789;

    // slot = last_draw / SLOT_DIV via floor reciprocal and a one-step correction
    localparam longint unsigned SLOT_DIV_L  = 1 + (64'd2147483562 / TABLE_ENTRIES);
    localparam int              RECIP_SHIFT = 37;
    localparam longint unsigned RECIP_L     = (64'd1 << RECIP_SHIFT) / SLOT_DIV_L;
    localparam int              RECIP_W     = $clog2(RECIP_L + 1);
    localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(RECIP_L);
    localparam logic [30:0]     SLOT_DIV    = 31'(SLOT_DIV_L);

    localparam logic CMD_RESEED   = 1'b0;
    localparam logic CMD_GENERATE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED_MUL,
        ST_SEED_RED,
        ST_DRAW_MUL,
        ST_DRAW_RED,
        ST_DRAW_FIX,
        ST_DRAW_UPD
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_SEED,
        OP_MUL,
        OP_STEP_A,
        OP_FILL,
        OP_STEP_AB,
        OP_FIX,
        OP_UPD
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [SLOT_W-1:0] fill_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic out_stall;
    } dp_stat_t;

    // p mod m for m = 2^31 - k, p below 2^47
    function automatic logic [30:0] mod_reduce(input logic [46:0] p, input logic [7:0] k,
                                               input logic [30:0] m);
        logic [31:0] s;
        logic [31:0] t;
        s = {1'b0, p[30:0]} + ({16'd0, p[46:31]} * {24'd0, k});
        t = {1'b0, s[30:0]} + (s[31] ? {24'd0, k} : 32'd0);
        if (t[30:0] >= m)
        begin
            return t[30:0] - m;
        end
        return t[30:0];
    endfunction

endpackage

// File: hdl/combined_lcg_shuffle_uniform_rng.sv
// Top level of the combined two-LCG uniform generator with shuffle table.
//
// Input channel s_*: one item is a command. s_tuser[0] selects reseed (0) or
// generate (1); s_tdata[30:0] carries the seed, read only on reseed.
// Output channel m_*: one item per accepted command, m_tdata[30:0] is the
// draw in [1, 2147483305], standing for draw / 2147483563.
// Generate: the result is registered after the multiply/reduce of the LCG
// units, slot correction and table read-modify-write; no new command is
// taken until then, and a stalled output holds back the table write.
// Reseed: each of the 40 (WARMUP_STEPS + TABLE_ENTRIES) seed steps is one
// multiply/reduce pass of the first LCG unit, and a draw follows the last
// step; no new command is taken meanwhile.
// Reset (rst_n low, asynchronous) loads first state 1, second state
// 123456789, last draw 0 and a zero shuffle table.
// A stalled receiver holds the result in the output register; the next
// command is still accepted and runs until it needs that register.
`timescale 1ns / 1ps

module combined_lcg_shuffle_uniform_rng
    import crng_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [30:0] seed, [31] zero
    input  logic [0:0]  s_tuser,   // [0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [30:0] random_value, [31] zero
);

    dp_cmd_t     dp_cmd;
    dp_stat_t    stat;
    logic [30:0] result;

    crng_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (s_tuser[0]),
        .stat     (stat),
        .dp_cmd   (dp_cmd)
    );

    crng_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .seed     (s_tdata[30:0]),
        .dp_cmd   (dp_cmd),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (result),
        .stat     (stat)
    );

    assign m_tdata = {1'b0, result};

endmodule

// File: hdl/crng_ctrl.sv
// Controller state machine: sequences reseed steps and the draw pipeline.
`timescale 1ns / 1ps

module crng_ctrl
    import crng_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  logic     cmd,
    input  dp_stat_t stat,
    output dp_cmd_t  dp_cmd
);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [STEP_W-1:0] fill_cnt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign fill_cnt = STEP_W'(SEED_STEPS - 1) - step_reg;

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        s_tready        = 1'b0;
        dp_cmd.op       = OP_NONE;
        dp_cmd.fill_idx = fill_cnt[SLOT_W-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (cmd == CMD_RESEED)
                    begin
                        dp_cmd.op  = OP_SEED;
                        step_next  = '0;
                        state_next = ST_SEED_MUL;
                    end
                    else
                    begin
                        dp_cmd.op  = OP_MUL;
                        state_next = ST_DRAW_RED;
                    end
                end
            end
            ST_SEED_MUL:
            begin
                dp_cmd.op  = OP_MUL;
                state_next = ST_SEED_RED;
            end
            ST_SEED_RED:
            begin
                dp_cmd.op = (step_reg >= STEP_W'(WARMUP_STEPS)) ? OP_FILL : OP_STEP_A;
                if (step_reg == STEP_W'(SEED_STEPS - 1))
                begin
                    state_next = ST_DRAW_MUL;
                end
                else
                begin
                    step_next  = step_reg + STEP_W'(1);
                    state_next = ST_SEED_MUL;
                end
            end
            ST_DRAW_MUL:
            begin
                dp_cmd.op  = OP_MUL;
                state_next = ST_DRAW_RED;
            end
            ST_DRAW_RED:
            begin
                dp_cmd.op  = OP_STEP_AB;
                state_next = ST_DRAW_FIX;
            end
            ST_DRAW_FIX:
            begin
                dp_cmd.op  = OP_FIX;
                state_next = ST_DRAW_UPD;
            end
            ST_DRAW_UPD:
            begin
                if (!stat.out_stall)
                begin
                    dp_cmd.op  = OP_UPD;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg != ST_IDLE)
        else $error("accepted item did not start work");

    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SEED_RED |-> step_reg <= STEP_W'(SEED_STEPS - 1))
        else $error("seed step counter out of range");

    a_upd_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DRAW_UPD && !stat.out_stall |=> state_reg == ST_IDLE)
        else $error("draw did not finish after result write");

endmodule

// File: hdl/crng_datapath.sv
// Datapath: two LCG units, shuffle table, slot divider and output register.
`timescale 1ns / 1ps

module crng_datapath
    import crng_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [30:0] seed,
    input  dp_cmd_t     dp_cmd,
    input  logic        m_tready,
    output logic        m_tvalid,
    output logic [30:0] m_tdata,
    output dp_stat_t    stat
);

    logic [30:0]            first_reg, first_next;
    logic [30:0]            second_reg, second_next;
    logic [30:0]            last_reg, last_next;
    logic [30:0]            table_reg [TABLE_ENTRIES];
    logic [46:0]            pa_reg, pb_reg;
    logic [31+RECIP_W-1:0]  sp_reg;
    logic [Q_W-1:0]         qe_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic                   out_valid_reg;
    logic [30:0]            out_data_reg;

    logic [30:0]            red_a, red_b, seed_eff, tbl_rd;
    logic [Q_W:0]           qp1, q_fix;
    logic [Q_W+31:0]        bound;
    logic [SLOT_W-1:0]      slot_next;
    logic [32:0]            diff, diff_wrap;
    logic [30:0]            draw_val;

    assign red_a    = mod_reduce(pa_reg, FOLD_A, MOD_A);
    assign red_b    = mod_reduce(pb_reg, FOLD_B, MOD_B);
    assign seed_eff = (seed == 31'd0) ? 31'd1 : seed;

    assign qp1   = {1'b0, qe_reg} + (Q_W+1)'(1);
    assign bound = (Q_W+32)'(qp1) * (Q_W+32)'(SLOT_DIV);
    assign q_fix = ((Q_W+32)'(last_reg) >= bound) ? qp1 : {1'b0, qe_reg};
    assign slot_next = (q_fix >= (Q_W+1)'(TABLE_ENTRIES)) ? SLOT_W'(TABLE_ENTRIES - 1)
                                                          : q_fix[SLOT_W-1:0];

    assign tbl_rd    = table_reg[slot_reg];
    assign diff      = {2'b00, tbl_rd} - {2'b00, second_reg};
    assign diff_wrap = (diff[32] || diff == 33'd0) ? diff + {2'b00, WRAP_ADD} : diff;
    assign draw_val  = diff_wrap[30:0];

    always_comb
    begin
        first_next  = first_reg;
        second_next = second_reg;
        last_next   = last_reg;
        unique case (dp_cmd.op)
            OP_SEED:
            begin
                first_next  = seed_eff;
                second_next = seed_eff;
            end
            OP_STEP_A:
            begin
                first_next = red_a;
            end
            OP_FILL:
            begin
                first_next = red_a;
                if (dp_cmd.fill_idx == '0)
                begin
                    last_next = red_a;
                end
            end
            OP_STEP_AB:
            begin
                first_next  = red_a;
                second_next = red_b;
            end
            OP_UPD:
            begin
                last_next = draw_val;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg     <= 31'd1;
            second_reg    <= SECOND_INIT;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                table_reg[i] <= '0;
            end
        end
        else
        begin
            first_reg  <= first_next;
            second_reg <= second_next;
            last_reg   <= last_next;
            if (dp_cmd.op == OP_FILL)
            begin
                table_reg[dp_cmd.fill_idx] <= red_a;
            end
            else if (dp_cmd.op == OP_UPD)
            begin
                table_reg[slot_reg] <= first_reg;
            end
            if (dp_cmd.op == OP_UPD)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.op == OP_MUL)
        begin
            pa_reg <= 47'(first_reg) * 47'(MUL_A);
            pb_reg <= 47'(second_reg) * 47'(MUL_B);
            sp_reg <= (31+RECIP_W)'(last_reg) * (31+RECIP_W)'(RECIP);
        end
        if (dp_cmd.op == OP_STEP_AB)
        begin
            qe_reg <= Q_W'(sp_reg >> RECIP_SHIFT);
        end
        if (dp_cmd.op == OP_FIX)
        begin
            slot_reg <= slot_next;
        end
        if (dp_cmd.op == OP_UPD)
        begin
            out_data_reg <= (draw_val > OUT_LIMIT) ? OUT_LIMIT : draw_val;
        end
    end

    assign m_tvalid       = out_valid_reg;
    assign m_tdata        = out_data_reg;
    assign stat.out_stall = out_valid_reg && !m_tready;

    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg != 31'd0) && (out_data_reg <= OUT_LIMIT))
        else $error("result out of range");

endmodule
